// ----- rtl/krle_pkg.sv -----
package krle_pkg;

  localparam int LineDepthDefault = 48;
  localparam int PtrW = 6;

  localparam logic [7:0] KeyEnter = 8'h28;
  localparam logic [7:0] KeyEsc   = 8'h29;
  localparam logic [7:0] KeyBksp  = 8'h2A;
  localparam logic [7:0] KeyRight = 8'h4F;
  localparam logic [7:0] KeyLeft  = 8'h50;
  localparam logic [7:0] ShiftBits = 8'h22;

  localparam logic [15:0] DelayReset = 16'd400;
  localparam logic [15:0] IntervalReset = 16'd60;
  localparam logic [7:0] CapReset = 8'd128;

  localparam logic [1:0] RegDelay = 2'd0;
  localparam logic [1:0] RegInterval = 2'd1;
  localparam logic [1:0] RegCapacity = 2'd2;

  localparam logic [1:0] KindStatus = 2'd0;
  localparam logic [1:0] KindChar = 2'd1;
  localparam logic [1:0] KindQuit = 2'd2;

  typedef struct packed {
    logic [7:0]  modifiers;
    logic [7:0]  key_slot_0;
    logic [7:0]  key_slot_1;
    logic [7:0]  key_slot_2;
    logic [7:0]  key_slot_3;
    logic [7:0]  key_slot_4;
    logic [7:0]  key_slot_5;
    logic [31:0] time_ms;
  } report_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_out;
    logic [5:0] cursor_out;
    logic [5:0] length_out;
    logic [5:0] view_out;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_ACT, S_SHIFT_RD, S_SHIFT_WR, S_DEL_RD, S_DEL_WR,
    S_SEND_RD, S_SEND_OUT, S_NL, S_REPEAT, S_STATUS, S_QUIT
  } state_t;

  // memory request from the sequencer to the line store
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [6:0] wdata;
    logic [5:0] raddr;
  } mem_req_t;

  function automatic logic [6:0] map_key(input logic [7:0] code, input logic shift);
    logic [6:0] c;
    c = 7'd0;
    if (code >= 8'd4 && code <= 8'd29)
      c = 7'(shift ? 8'd61 + code : 8'd93 + code);
    else if (code >= 8'd30 && code <= 8'd38 && !shift)
      c = 7'(8'd19 + code);
    else begin
      case (code)
        8'd30: c = 7'h21;  8'd31: c = 7'h40;  8'd32: c = 7'h23;
        8'd33: c = 7'h24;  8'd34: c = 7'h25;  8'd35: c = 7'h5E;
        8'd36: c = 7'h26;  8'd37: c = 7'h2A;  8'd38: c = 7'h28;
        8'd39: c = shift ? 7'h29 : 7'h30;
        8'd44: c = 7'h20;
        8'd45: c = shift ? 7'h5F : 7'h2D;
        8'd46: c = shift ? 7'h2B : 7'h3D;
        8'd47: c = shift ? 7'h7B : 7'h5B;
        8'd48: c = shift ? 7'h7D : 7'h5D;
        8'd49: c = shift ? 7'h7C : 7'h5C;
        8'd51: c = shift ? 7'h3A : 7'h3B;
        8'd52: c = shift ? 7'h22 : 7'h27;
        8'd53: c = shift ? 7'h7E : 7'h60;
        8'd54: c = shift ? 7'h3C : 7'h2C;
        8'd55: c = shift ? 7'h3E : 7'h2E;
        8'd56: c = shift ? 7'h3F : 7'h2F;
        default: c = 7'd0;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- rtl/krle_store.sv -----
module krle_store import krle_pkg::*; #(
  parameter int LINE_DEPTH = LineDepthDefault
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [6:0] rdata
);
  logic [6:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ----- rtl/krle_ctrl.sv -----
module krle_ctrl import krle_pkg::*; #(
  parameter int LINE_DEPTH = LineDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  report_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output mem_req_t    mreq,
  input  logic [6:0]  mrdata
);
  localparam logic [5:0] MaxLen = 6'(LINE_DEPTH - 1);

  state_t state, state_next;
  report_t rpt;
  logic [15:0] delay_ms, interval_ms;
  logic [7:0] capacity;
  logic [5:0] len, cur, view;
  logic [7:0] prev [6];
  logic [7:0] rkey, rmods;
  logic [31:0] press_t, last_t;
  logic halted, sent, was_repeat;
  logic [2:0] slot;
  logic [7:0] act_code, act_mods;
  logic [5:0] idx;
  logic [6:0] ins_ch;

  logic [5:0] len_n, cur_n, view_n, idx_n;
  logic [2:0] slot_n;
  logic [7:0] act_code_n, act_mods_n, rkey_n, rmods_n;
  logic [31:0] press_n, last_n;
  logic halted_n, sent_n, upd_prev, was_repeat_n;
  logic [6:0] ins_n;
  logic [7:0] code;
  logic is_new, held;
  logic [6:0] mapped;
  logic [31:0] dt_press, dt_last;

  always_comb begin
    case (slot)
      3'd0: code = rpt.key_slot_0;
      3'd1: code = rpt.key_slot_1;
      3'd2: code = rpt.key_slot_2;
      3'd3: code = rpt.key_slot_3;
      3'd4: code = rpt.key_slot_4;
      default: code = rpt.key_slot_5;
    endcase
  end

  assign is_new = code != 8'd0 && code != prev[0] && code != prev[1] && code != prev[2]
                  && code != prev[3] && code != prev[4] && code != prev[5];
  assign held = rkey != 8'd0 && (rpt.key_slot_0 == rkey || rpt.key_slot_1 == rkey ||
                rpt.key_slot_2 == rkey || rpt.key_slot_3 == rkey ||
                rpt.key_slot_4 == rkey || rpt.key_slot_5 == rkey);
  assign mapped = map_key(act_code, (act_mods & ShiftBits) != 8'd0);
  assign dt_press = rpt.time_ms - press_t;
  assign dt_last = rpt.time_ms - last_t;

  // clamp view around the final cursor (cur_n, len_n)
  function automatic logic [5:0] clamp(input logic [5:0] c, input logic [5:0] l,
                                       input logic [5:0] v0, input logic [7:0] cap);
    logic [5:0] v;
    logic [8:0] e;
    v = (c < v0) ? c : v0;
    e = {3'd0, v} + {1'b0, cap};
    if ({3'd0, c} >= e) v = 6'({3'd0, c} + 9'd1 - {1'b0, cap});
    if (v > l) v = l;
    return v;
  endfunction

  always_comb begin
    state_next = state;
    len_n = len; cur_n = cur; view_n = view; idx_n = idx; slot_n = slot;
    act_code_n = act_code; act_mods_n = act_mods; rkey_n = rkey; rmods_n = rmods;
    press_n = press_t; last_n = last_t; halted_n = halted; sent_n = sent;
    ins_n = ins_ch; upd_prev = 1'b0; was_repeat_n = was_repeat;
    in_ready = 1'b0; out_valid = 1'b0;
    out_data = '0;
    mreq = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          slot_n = 3'd0; sent_n = 1'b0;
          state_next = halted ? S_QUIT : S_SLOT;
        end
      end
      S_SLOT: begin
        if (slot == 3'd6) begin
          upd_prev = 1'b1;
          state_next = S_REPEAT;
        end else begin
          slot_n = slot + 3'd1;
          if (is_new) begin
            rkey_n = code; rmods_n = rpt.modifiers;
            press_n = rpt.time_ms; last_n = rpt.time_ms;
            act_code_n = code; act_mods_n = rpt.modifiers;
            was_repeat_n = 1'b0;
            if (code == KeyEsc) begin
              halted_n = 1'b1; state_next = S_QUIT;
            end else if (code == KeyEnter) begin
              if (!sent && len != 6'd0) begin
                idx_n = 6'd0; state_next = S_SEND_RD;
              end else begin
                view_n = clamp(cur, len, view, capacity);
              end
            end else begin
              state_next = S_ACT;
            end
          end
        end
      end
      S_REPEAT: begin
        rkey_n = held ? rkey : 8'd0;
        state_next = S_STATUS;
        if (held && dt_press >= {16'd0, delay_ms} && dt_last >= {16'd0, interval_ms}) begin
          last_n = rpt.time_ms;
          if (rkey != KeyEnter && rkey != KeyEsc) begin
            act_code_n = rkey; act_mods_n = rmods; was_repeat_n = 1'b1;
            state_next = S_ACT;
          end else begin
            view_n = clamp(cur, len, view, capacity);
          end
        end
      end
      S_ACT: begin
        state_next = was_repeat ? S_STATUS : S_SLOT;
        if (act_code == KeyBksp) begin
          if (cur != 6'd0) begin
            idx_n = cur; state_next = S_DEL_RD;
          end else view_n = clamp(cur, len, view, capacity);
        end else if (act_code == KeyLeft && cur != 6'd0) begin
          cur_n = cur - 6'd1; view_n = clamp(cur_n, len, view, capacity);
        end else if (act_code == KeyRight && cur < len) begin
          cur_n = cur + 6'd1; view_n = clamp(cur_n, len, view, capacity);
        end else if (mapped != 7'd0 && mapped != 7'h0A && len < MaxLen) begin
          ins_n = mapped; idx_n = len; state_next = S_SHIFT_RD;
        end else begin
          view_n = clamp(cur, len, view, capacity);
        end
      end
      S_SHIFT_RD: begin
        // move entry idx-1 up to idx, walking down to the cursor
        if (idx == cur) begin
          mreq.we = 1'b1; mreq.waddr = cur; mreq.wdata = ins_ch;
          len_n = len + 6'd1; cur_n = cur + 6'd1;
          view_n = clamp(cur_n, len_n, view, capacity);
          state_next = was_repeat ? S_STATUS : S_SLOT;
        end else begin
          mreq.raddr = idx - 6'd1; state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mreq.we = 1'b1; mreq.waddr = idx; mreq.wdata = mrdata;
        idx_n = idx - 6'd1; state_next = S_SHIFT_RD;
      end
      S_DEL_RD: begin
        if (idx >= len) begin
          len_n = len - 6'd1; cur_n = cur - 6'd1;
          view_n = clamp(cur_n, len_n, view, capacity);
          state_next = was_repeat ? S_STATUS : S_SLOT;
        end else begin
          mreq.raddr = idx; state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mreq.we = 1'b1; mreq.waddr = idx - 6'd1; mreq.wdata = mrdata;
        idx_n = idx + 6'd1; state_next = S_DEL_RD;
      end
      S_SEND_RD: begin
        mreq.raddr = idx; state_next = S_SEND_OUT;
      end
      S_SEND_OUT: begin
        // keep the read address so the char stays put while stalled
        mreq.raddr = idx;
        out_valid = 1'b1;
        out_data.kind = KindChar; out_data.char_out = mrdata;
        if (out_ready) begin
          idx_n = idx + 6'd1;
          state_next = (idx_n == len) ? S_NL : S_SEND_RD;
        end
      end
      S_NL: begin
        out_valid = 1'b1;
        out_data.kind = KindChar; out_data.char_out = 7'h0A;
        if (out_ready) begin
          len_n = 6'd0; cur_n = 6'd0; view_n = 6'd0; sent_n = 1'b1;
          state_next = S_SLOT;
        end
      end
      S_STATUS: begin
        out_valid = 1'b1;
        out_data.kind = KindStatus; out_data.cursor_out = cur;
        out_data.length_out = len; out_data.view_out = view; out_data.last = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      S_QUIT: begin
        out_valid = 1'b1;
        out_data.kind = KindQuit; out_data.cursor_out = cur;
        out_data.length_out = len; out_data.view_out = view; out_data.last = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      delay_ms <= DelayReset; interval_ms <= IntervalReset; capacity <= CapReset;
      len <= '0; cur <= '0; view <= '0;
      for (int k = 0; k < 6; k++) prev[k] <= '0;
      rkey <= '0; rmods <= '0; press_t <= '0; last_t <= '0; halted <= 1'b0;
      sent <= 1'b0; slot <= '0; was_repeat <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_n; cur <= cur_n; view <= view_n;
      rkey <= rkey_n; rmods <= rmods_n; press_t <= press_n; last_t <= last_n;
      halted <= halted_n; sent <= sent_n; slot <= slot_n; was_repeat <= was_repeat_n;
      if (upd_prev) begin
        prev[0] <= rpt.key_slot_0; prev[1] <= rpt.key_slot_1;
        prev[2] <= rpt.key_slot_2; prev[3] <= rpt.key_slot_3;
        prev[4] <= rpt.key_slot_4; prev[5] <= rpt.key_slot_5;
      end
      if (cfg_valid) begin
        case (cfg_index)
          RegDelay: delay_ms <= cfg_data;
          RegInterval: interval_ms <= cfg_data;
          RegCapacity: capacity <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) rpt <= in_data;
    act_code <= act_code_n; act_mods <= act_mods_n;
    idx <= idx_n; ins_ch <= ins_n;
  end
endmodule

// ----- rtl/keyboard_report_line_editor_unit.sv -----
// Flow: after a report beat the six key slots are scanned, then key repeat is checked,
// then one status or quit beat is sent; an insert or delete moves line entries one at
// a time through the store, and Enter sends each char of the line and then a newline.
// Throughput: one report at a time; in_ready stays low until the last beat is taken;
// each entry move is a registered read of the line store followed by a write.
// Reset: synchronous active-high rst clears editor state and registers to defaults;
// line store contents are left as they are.
module keyboard_report_line_editor_unit import krle_pkg::*; #(
  parameter int LINE_DEPTH = LineDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  report_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  // store request and read data between sequencer and line memory
  mem_req_t   mreq;
  logic [6:0] mrdata;

  // configuration beats are always taken
  assign cfg_ready = 1'b1;

  krle_ctrl #(.LINE_DEPTH(LINE_DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_index, .cfg_data, .mreq, .mrdata
  );

  krle_store #(.LINE_DEPTH(LINE_DEPTH)) u_store (
    .clk, .req(mreq), .rdata(mrdata)
  );
endmodule

// ----- rtl/krle_checker.sv -----
module krle_checker import krle_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KindStatus |-> out_data.cursor_out <= out_data.length_out)
    else $error("cursor past line end");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KindChar |-> !out_data.last)
    else $error("char beat marked last");
endmodule

bind keyboard_report_line_editor_unit krle_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

// ----- bench/krle_scoreboard.sv -----
`timescale 1ns / 100ps
module krle_scoreboard import krle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  report_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          waiting
);

  localparam int Depth = LineDepthDefault;

  result_t     line_results[$];

  // editor state as the block should hold it
  logic [6:0]  store [Depth];
  int unsigned len, cur, view;
  int unsigned delay_ms, interval_ms, capacity;
  logic [7:0]  last_keys [6];
  logic [7:0]  rep_key, rep_mods;
  logic [31:0] press_ms, rep_ms;
  bit          halted;

  assign waiting = line_results.size();

  function automatic logic [6:0] glyph(input logic [7:0] code, input logic shift);
    string plain_sym, shift_sym, digit_sym;
    plain_sym = "-=[]\\?;'`,./";
    shift_sym = "_+{}|?:\"~<>?";
    digit_sym = "!@#$%^&*(";
    if (code >= 4 && code <= 29) return shift ? 7'(8'h41 + code - 4) : 7'(8'h61 + code - 4);
    if (code >= 30 && code <= 38) return shift ? 7'(digit_sym[code - 30])
                                               : 7'(8'h31 + code - 30);
    if (code == 39) return shift ? 7'h29 : 7'h30;
    if (code == 44) return 7'h20;
    if (code >= 45 && code <= 56 && code != 50)
      return shift ? 7'(shift_sym[code - 45]) : 7'(plain_sym[code - 45]);
    return 7'd0;
  endfunction

  function automatic void settle_view();
    if (cur < view) view = cur;
    if (cur >= view + capacity) view = cur + 1 - capacity;
    if (view > len) view = len;
  endfunction

  function automatic void place_char(input logic [6:0] ch);
    if (len >= Depth - 1) return;
    for (int unsigned i = len; i > cur; i--) store[i] = store[i - 1];
    store[cur] = ch;
    len++;
    cur++;
  endfunction

  function automatic void rub_out();
    if (cur == 0) return;
    for (int unsigned i = cur - 1; i + 1 < len; i++) store[i] = store[i + 1];
    len--;
    cur--;
  endfunction

  function automatic void key_action(input logic [7:0] code, input logic [7:0] mods);
    logic [6:0] ch;
    ch = glyph(code, |(mods & ShiftBits));
    if (code == KeyBksp) rub_out();
    else if (code == KeyLeft && cur > 0) cur--;
    else if (code == KeyRight && cur < len) cur++;
    else if (ch != 0 && ch != 7'h0A) place_char(ch);
    settle_view();
  endfunction

  function automatic void expect_beat(input logic [1:0] kind, input logic [6:0] ch,
                                      input logic fin);
    result_t r;
    r.kind       = kind;
    r.char_out   = ch;
    r.cursor_out = (kind != KindChar) ? 6'(cur) : 6'd0;
    r.length_out = (kind != KindChar) ? 6'(len) : 6'd0;
    r.view_out   = (kind != KindChar) ? 6'(view) : 6'd0;
    r.last       = fin;
    line_results.push_back(r);
  endfunction

  function automatic void edit_report(input report_t r);
    logic [7:0] keys [6];
    bit sent, was, held;
    if (halted) begin
      expect_beat(KindQuit, 0, 1'b1);
      return;
    end
    keys = '{r.key_slot_0, r.key_slot_1, r.key_slot_2,
             r.key_slot_3, r.key_slot_4, r.key_slot_5};
    sent = 0;
    for (int i = 0; i < 6; i++) begin
      if (keys[i] == 0) continue;
      was = 0;
      foreach (last_keys[j]) if (last_keys[j] == keys[i]) was = 1;
      if (was) continue;
      rep_key  = keys[i];
      rep_mods = r.modifiers;
      press_ms = r.time_ms;
      rep_ms   = r.time_ms;
      if (keys[i] == KeyEsc) begin
        halted = 1;
        expect_beat(KindQuit, 0, 1'b1);
        return;
      end
      if (keys[i] == KeyEnter) begin
        if (!sent && len > 0) begin
          for (int unsigned k = 0; k < len; k++) expect_beat(KindChar, store[k], 1'b0);
          expect_beat(KindChar, 7'h0A, 1'b0);
          len = 0;
          cur = 0;
          view = 0;
          sent = 1;
        end
        settle_view();
      end else begin
        key_action(keys[i], r.modifiers);
      end
    end
    last_keys = keys;
    held = 0;
    foreach (keys[i]) if (rep_key != 0 && keys[i] == rep_key) held = 1;
    if (!held) rep_key = 0;
    if (rep_key != 0 && 32'(r.time_ms - press_ms) >= delay_ms &&
        32'(r.time_ms - rep_ms) >= interval_ms) begin
      rep_ms = r.time_ms;
      if (rep_key != KeyEnter && rep_key != KeyEsc) key_action(rep_key, rep_mods);
      else settle_view();
    end
    expect_beat(KindStatus, 0, 1'b1);
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      fails = 0;
      line_results.delete();
      delay_ms = DelayReset;
      interval_ms = IntervalReset;
      capacity = CapReset;
      len = 0;
      cur = 0;
      view = 0;
      foreach (last_keys[i]) last_keys[i] = 0;
      rep_key = 0;
      rep_mods = 0;
      press_ms = 0;
      rep_ms = 0;
      halted = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_results.size() == 0) begin
          $error("unexpected result beat %h", out_data);
          fails++;
        end else begin
          e = line_results.pop_front();
          if (out_data.kind != e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_data.kind); fails++;
          end
          if (out_data.char_out != e.char_out) begin
            $error("char_out exp %h got %h", e.char_out, out_data.char_out); fails++;
          end
          if (out_data.cursor_out != e.cursor_out) begin
            $error("cursor_out exp %0d got %0d", e.cursor_out, out_data.cursor_out); fails++;
          end
          if (out_data.length_out != e.length_out) begin
            $error("length_out exp %0d got %0d", e.length_out, out_data.length_out); fails++;
          end
          if (out_data.view_out != e.view_out) begin
            $error("view_out exp %0d got %0d", e.view_out, out_data.view_out); fails++;
          end
          if (out_data.last != e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last); fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegDelay:    delay_ms = cfg_data;
          RegInterval: interval_ms = cfg_data;
          RegCapacity: capacity = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) edit_report(in_data);
    end
  end

endmodule

// ----- bench/keyboard_report_line_editor_unit_tb.sv -----
`timescale 1ns / 100ps
module keyboard_report_line_editor_unit_tb;
  import krle_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  report_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  result_t     out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fails, waiting;

  // idle percentages for the current phase
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // stimulus keyboard state
  logic [31:0] clock_ms;
  logic [7:0]  held [6];

  always #5 clk = ~clk;

  keyboard_report_line_editor_unit DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  krle_scoreboard checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fails, .waiting
  );

  // Receiver: random stalls, plus a long hold-off on request so the
  // block backs up and drops in_ready while reports keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 600;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("keyboard_report_line_editor_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // One report beat. Valid stays up across back-to-back beats; it only
  // drops when an idle gap is drawn.
  task automatic send_report(input report_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_keys(input logic [7:0] mods, input logic [7:0] k0, k1, k2, k3, k4,
                           k5, input int unsigned step_ms);
    report_t r;
    clock_ms = clock_ms + step_ms;
    r = '{mods, k0, k1, k2, k3, k4, k5, clock_ms};
    send_report(r);
  endtask

  // Registers only change once the block has drained.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [7:0] pick_key();
    int sel;
    logic [7:0] k;
    sel = $urandom_range(99);
    if (sel < 8) return KeyEnter;
    if (sel < 16) return KeyBksp;
    if (sel < 22) return KeyLeft;
    if (sel < 28) return KeyRight;
    k = 8'($urandom_range(56, 4));
    return (k == KeyEsc) ? 8'h00 : k;
  endfunction

  // Mostly plausible typing: presses, holds that repeat, releases; the rest
  // is raw noise in every slot (ESC kept out until the end).
  task automatic random_reports(input int count);
    logic [7:0] noise [6];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(99);
      if (mode < 15) begin
        foreach (noise[i]) begin
          noise[i] = 8'($urandom);
          if (noise[i] == KeyEsc) noise[i] = 0;
        end
        send_keys(8'($urandom), noise[0], noise[1], noise[2], noise[3], noise[4], noise[5],
                  $urandom);
      end else begin
        if (mode < 30) begin
          foreach (held[i]) held[i] = 0;
        end else if (mode < 70) begin
          foreach (held[i]) if ($urandom_range(2) == 0) held[i] = pick_key();
          if ($urandom_range(1)) held[$urandom_range(5)] = 0;
        end
        send_keys($urandom_range(1) ? 8'($urandom) : 8'h00,
                  held[0], held[1], held[2], held[3], held[4], held[5],
                  ($urandom_range(3) == 0) ? $urandom_range(600) : $urandom_range(80));
      end
    end
  endtask

  initial begin
    foreach (held[i]) held[i] = 0;
    clock_ms = 32'hFFFF_FE00;   // repeat timing crosses the time wrap early
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: shift sides, key code extremes, ends of line, double slots,
    // empty Enter, two Enters in one report.
    send_keys(8'h02, 8'h04, 0, 0, 0, 0, 0, 1);
    send_keys(8'h20, 8'h38, 0, 0, 0, 0, 0, 1);
    send_keys(8'hDD, 8'h27, 8'h1E, 0, 0, 0, 0, 1);
    send_keys(8'h00, 8'hFF, 8'h40, 8'h39, 8'h32, 8'h2B, 0, 1);
    send_keys(8'h00, 0, 0, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyRight, 0, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyLeft, 8'h05, 8'h05, 0, 0, 0, 1);
    send_keys(8'h00, 0, 0, 0, 0, 0, 0, 1);
    for (int i = 0; i < 6; i++) send_keys(8'h00, KeyLeft, 0, 0, 0, 0, 0, 0) ;
    send_keys(8'h00, 0, KeyLeft, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyBksp, 8'h2C, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyEnter, 8'h10, KeyEnter, 0, 0, 0, 1);
    send_keys(8'h00, 0, 0, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyEnter, 0, 0, 0, 0, 0, 1);
    // fill the line to its maximum length, then send it all: the longest burst
    for (int i = 0; i < 9; i++)
      send_keys(8'h00, 8'(4 + 6 * (i % 2)), 8'(5 + 6 * (i % 2)), 8'(6 + 6 * (i % 2)),
                8'(7 + 6 * (i % 2)), 8'(8 + 6 * (i % 2)), 8'(9 + 6 * (i % 2)), 1);
    send_keys(8'h00, KeyEnter, 0, 0, 0, 0, 0, 1);

    // Fastest repeat, narrowest window.
    write_reg(RegDelay, 16'd0);
    write_reg(RegInterval, 16'd0);
    write_reg(RegCapacity, 16'hFF01);
    write_reg(2'd3, 16'hFFFF);
    send_keys(8'h00, 8'h06, 0, 0, 0, 0, 0, 0);
    send_keys(8'h00, 8'h06, 0, 0, 0, 0, 0, 0);
    send_keys(8'h00, KeyEnter, 0, 0, 0, 0, 0, 0);
    send_keys(8'h00, KeyEnter, 0, 0, 0, 0, 0, 0);
    hold_req = 1;               // long receiver hold while reports keep coming
    random_reports(19);

    // Slowest repeat, default window; sender idles.
    write_reg(RegDelay, 16'hFFFF);
    write_reg(RegInterval, 16'hFFFF);
    write_reg(RegCapacity, 16'd128);
    send_idle_pct = 65;
    random_reports(19);

    // Random settings; receiver stalls.
    write_reg(RegDelay, 16'($urandom_range(300)));
    write_reg(RegInterval, 16'($urandom_range(100)));
    write_reg(RegCapacity, 16'($urandom_range(12, 1)));
    send_idle_pct = 0;
    stall_pct = 65;
    random_reports(19);

    // Defaults-like settings; both sides idle.
    write_reg(RegDelay, 16'd400);
    write_reg(RegInterval, 16'd60);
    write_reg(RegCapacity, 16'($urandom_range(128, 1)));
    send_idle_pct = 33;
    stall_pct = 33;
    random_reports(19);

    // ESC after a press in an earlier slot halts; later reports only quit.
    send_keys(8'h00, 0, 0, 0, 0, 0, 0, 1);
    send_keys(8'h00, 8'h14, KeyEsc, 8'h1A, 0, 0, 0, 1);
    send_keys(8'h00, 8'h04, 0, 0, 0, 0, 0, 1);
    send_keys(8'h00, KeyEnter, 0, 0, 0, 0, 0, 1);
    in_valid <= 0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("keyboard_report_line_editor_unit_tb OK");
    end else begin
      $display("keyboard_report_line_editor_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
